FILE: hw/rtl/moesif_snoop_line_controller_unit_defines.svh
// Assertion macros shared by the MOESIF snoop line controller RTL.
// No dependencies; included by the files that carry assertions.
`ifndef MOESIF_SNOOP_LINE_CONTROLLER_UNIT_DEFINES_SVH
`define MOESIF_SNOOP_LINE_CONTROLLER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, masked while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/msl_pkg.sv
// Types, codes and item structures of the MOESIF snoop line controller.
// No dependencies; imported by every module of the block.
package msl_pkg;

    // Line states, stable then transient
    typedef enum logic [3:0] {
        ST_I  = 4'd0,
        ST_S  = 4'd1,
        ST_E  = 4'd2,
        ST_O  = 4'd3,
        ST_M  = 4'd4,
        ST_F  = 4'd5,
        ST_IS = 4'd6,
        ST_IM = 4'd7,
        ST_SM = 4'd8,
        ST_OM = 4'd9,
        ST_FM = 4'd10
    } t_line_state;

    // Request codes on the input channel
    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_STORE = 3'd1;
    localparam logic [2:0] OP_GETS  = 3'd2;
    localparam logic [2:0] OP_GETM  = 3'd3;
    localparam logic [2:0] OP_DATA  = 3'd4;

    // Bus request codes
    localparam logic [1:0] BUS_NONE = 2'd0;
    localparam logic [1:0] BUS_GETS = 2'd1;
    localparam logic [1:0] BUS_GETM = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_IGNORED = 2'd1;
    localparam logic [1:0] STAT_ILLEGAL = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] addr;
        logic [3:0]  src_id;
        logic        shared_in;
    } t_item;

    typedef struct packed {
        logic [1:0]  bus_req;
        logic        proc_data;
        logic        bus_data;
        logic [3:0]  bus_data_dest;
        logic        assert_shared;
        logic [31:0] addr_out;
        logic        miss_event;
        logic        upgrade_event;
        logic [1:0]  status;
        t_line_state line_state_out;
    } t_result;

endpackage

FILE: hw/rtl/msl_transition.sv
// Next-state and result logic of one MOESIF line for one transfer.
// Depends on msl_pkg.
module msl_transition
    import msl_pkg::*;
(
    input  t_item       i_item,
    input  t_line_state i_state,
    input  logic [3:0]  i_own_id,
    output t_result     o_result
);

    t_line_state st;
    t_line_state nst;
    logic [1:0]  req;
    logic        pd;
    logic        bd;
    logic        sh;
    logic        miss;
    logic        upg;
    logic [1:0]  status;
    logic        store;
    logic        other;

    always_comb begin
        // unused codes above FM behave as I
        st     = (i_state > ST_FM) ? ST_I : i_state;
        nst    = st;
        req    = BUS_NONE;
        pd     = 1'b0;
        bd     = 1'b0;
        sh     = 1'b0;
        miss   = 1'b0;
        upg    = 1'b0;
        status = STAT_OK;
        store  = (i_item.op == OP_STORE);
        other  = (i_item.src_id != i_own_id);

        case (i_item.op)
            OP_LOAD, OP_STORE: begin
                case (st)
                    ST_I: begin
                        req  = store ? BUS_GETM : BUS_GETS;
                        nst  = store ? ST_IM : ST_IS;
                        miss = 1'b1;
                    end
                    ST_S, ST_O, ST_F: begin
                        if (store) begin
                            req  = BUS_GETM;
                            miss = 1'b1;
                            nst  = (st == ST_S) ? ST_IM : (st == ST_O) ? ST_OM : ST_FM;
                        end else begin
                            pd = 1'b1;
                        end
                    end
                    ST_E: begin
                        pd = 1'b1;
                        if (store) begin
                            nst = ST_M;
                            upg = 1'b1;
                        end
                    end
                    ST_M: begin
                        pd = 1'b1;
                    end
                    default: begin
                        // transient: drop the processor request
                        status = STAT_IGNORED;
                    end
                endcase
            end
            OP_GETS, OP_GETM, OP_DATA: begin
                case (st)
                    ST_I: begin
                    end
                    ST_S: begin
                        if (i_item.op == OP_GETS) begin
                            sh = 1'b1;
                        end else if (i_item.op == OP_GETM) begin
                            nst = ST_I;
                        end
                    end
                    ST_E, ST_M: begin
                        if (i_item.op == OP_GETS) begin
                            sh  = 1'b1;
                            bd  = 1'b1;
                            nst = (st == ST_E) ? ST_F : ST_O;
                        end else if (i_item.op == OP_GETM) begin
                            sh  = 1'b1;
                            bd  = 1'b1;
                            nst = ST_I;
                        end
                    end
                    ST_O, ST_F: begin
                        if (i_item.op == OP_GETS) begin
                            sh = 1'b1;
                            bd = 1'b1;
                        end else if (i_item.op == OP_GETM) begin
                            sh  = 1'b1;
                            bd  = 1'b1;
                            nst = ST_I;
                        end else if (st == ST_F) begin
                            status = STAT_ILLEGAL;
                        end
                    end
                    ST_IS: begin
                        if (i_item.op == OP_DATA) begin
                            pd  = 1'b1;
                            nst = i_item.shared_in ? ST_S : ST_E;
                        end
                    end
                    ST_IM: begin
                        if (i_item.op == OP_DATA) begin
                            pd  = 1'b1;
                            nst = ST_M;
                        end
                    end
                    ST_SM: begin
                        if (i_item.op == OP_DATA) begin
                            pd  = 1'b1;
                            nst = ST_M;
                        end else begin
                            sh = (i_item.op == OP_GETS);
                            if (other) begin
                                nst = ST_IM;
                            end
                        end
                    end
                    ST_OM, ST_FM: begin
                        if (i_item.op == OP_GETS) begin
                            sh = 1'b1;
                            bd = 1'b1;
                        end else if (i_item.op == OP_GETM) begin
                            bd = 1'b1;
                            if (st == ST_OM || other) begin
                                nst = ST_IM;
                            end
                        end else begin
                            pd  = 1'b1;
                            nst = ST_M;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                status = STAT_ILLEGAL;
            end
        endcase
    end

    // Assemble the result; address and destination only with activity
    always_comb begin
        o_result.bus_req        = req;
        o_result.proc_data      = pd;
        o_result.bus_data       = bd;
        o_result.bus_data_dest  = bd ? i_item.src_id : 4'd0;
        o_result.assert_shared  = sh;
        o_result.addr_out       = ((req != BUS_NONE) || pd || bd) ? i_item.addr : 32'd0;
        o_result.miss_event     = miss;
        o_result.upgrade_event  = upg;
        o_result.status         = status;
        o_result.line_state_out = nst;
    end

endmodule

FILE: hw/rtl/moesif_snoop_line_controller_unit.sv
// Top level of the MOESIF snoop line controller: input register, line state,
// result register and assertions. Depends on msl_pkg, msl_transition and
// moesif_snoop_line_controller_unit_defines.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one processor load or
//   store, or one snooped GETS, GETM or DATA, with address, requester id and
//   the sampled shared line. Each transfer yields exactly one result on the
//   output channel (o_out_valid / i_out_stall).
//   Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_data) writes the
//   own module id; it is always ready. The user must write it only while idle;
//   the block itself does not enforce this. Each result passes the input
//   register, then the result register; a receiver stall can hold it in either.
//   Throughput: one transfer per cycle while the receiver does not stall; the
//   line state is updated in the same cycle the result register loads, so the
//   next item sees it at once.
//   Reset (synchronous, active low) returns the line to I, the own id to 0
//   and empties both registers.
//   Receiver stall holds the result register; the input register holds
//   behind it and o_in_stall rises once both are full.
`include "moesif_snoop_line_controller_unit_defines.svh"

module moesif_snoop_line_controller_unit
    import msl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [31:0] i_addr,
    input  logic [3:0]  i_src_id,
    input  logic        i_shared_in,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_bus_req,
    output logic        o_proc_data,
    output logic        o_bus_data,
    output logic [3:0]  o_bus_data_dest,
    output logic        o_assert_shared,
    output logic [31:0] o_addr_out,
    output logic        o_miss_event,
    output logic        o_upgrade_event,
    output logic [1:0]  o_status,
    output logic [3:0]  o_line_state_out
);

    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    t_result     r_out;
    t_line_state r_line_state;
    logic [3:0]  r_own_id;

    logic        w_advance;
    logic        w_fire;
    t_result     w_result;

    // Result register frees when empty or taken this cycle
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_advance;
    assign o_in_stall = r_in_valid && !w_advance;
    assign o_cfg_ready = 1'b1;

    msl_transition u_transition (
        .i_item   (r_in),
        .i_state  (r_line_state),
        .i_own_id (r_own_id),
        .o_result (w_result)
    );

    // Control registers: valids, line state and own id
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_line_state <= ST_I;
            r_own_id     <= 4'd0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_line_state <= w_result.line_state_out;
            end
            if (i_cfg_valid) begin
                r_own_id <= i_cfg_data;
            end
        end
    end

    // Payload registers: capture the input transfer, load the result
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in.op        <= i_op;
            r_in.addr      <= i_addr;
            r_in.src_id    <= i_src_id;
            r_in.shared_in <= i_shared_in;
        end
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_bus_req        = r_out.bus_req;
    assign o_proc_data      = r_out.proc_data;
    assign o_bus_data       = r_out.bus_data;
    assign o_bus_data_dest  = r_out.bus_data_dest;
    assign o_assert_shared  = r_out.assert_shared;
    assign o_addr_out       = r_out.addr_out;
    assign o_miss_event     = r_out.miss_event;
    assign o_upgrade_event  = r_out.upgrade_event;
    assign o_status         = r_out.status;
    assign o_line_state_out = r_out.line_state_out;

    // Held result always reports the current line state
    `ASSERT_IMPLIES(a_state_tracks, i_clk, i_rst_n, o_out_valid,
        o_line_state_out == r_line_state)
    // Address is only driven alongside a request or data
    `ASSERT_IMPLIES(a_addr_gated, i_clk, i_rst_n, o_out_valid && (o_addr_out != 32'd0),
        (o_bus_req != BUS_NONE) || o_proc_data || o_bus_data)
    // Ignored processor request leaves bus and processor untouched
    `ASSERT_IMPLIES(a_ignored_quiet, i_clk, i_rst_n, o_out_valid && (o_status == STAT_IGNORED),
        (o_bus_req == BUS_NONE) && !o_proc_data && !o_bus_data && !o_miss_event)
    // A pending item with a free result register shows a result next cycle
    `ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, r_in_valid && !r_out_valid,
        o_out_valid)

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the MOESIF snoop line controller.
// Needs msl_pkg and moesif_snoop_line_controller_unit; a directed table is followed
// by random phases under several own-id settings, all checked by a line-state predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import msl_pkg::*;

    // Op codes with no meaning to the block
    localparam logic [2:0] OP_BAD_LO = 3'd5;
    localparam logic [2:0] OP_BAD_HI = 3'd7;

    localparam int HOLD_CYCLES   = 48;
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_ITEMS   = 100;
    localparam int PHASE_COUNT   = 6;
    localparam int DRAIN_CYCLES  = 8;

    typedef struct {
        t_item   req;
        bit      pinned;
        t_result want;
    } t_stim_row;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data   = 4'd0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_op         = OP_LOAD;
    logic [31:0] i_addr       = 32'd0;
    logic [3:0]  i_src_id     = 4'd0;
    logic        i_shared_in  = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [1:0]  o_bus_req;
    logic        o_proc_data;
    logic        o_bus_data;
    logic [3:0]  o_bus_data_dest;
    logic        o_assert_shared;
    logic [31:0] o_addr_out;
    logic        o_miss_event;
    logic        o_upgrade_event;
    logic [1:0]  o_status;
    logic [3:0]  o_line_state_out;

    // Predictor state and expected results in transfer order
    t_line_state line_model   = ST_I;
    logic [3:0]  own_id_model = 4'd0;
    t_result     pending_results[$];
    t_stim_row   stim_rows[$];

    // Pinned expectation of the item currently offered
    bit          drv_pinned   = 1'b0;
    t_result     drv_expect;

    bit          hold_pending = 1'b0;
    int          mismatches   = 0;

    moesif_snoop_line_controller_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_addr           (i_addr),
        .i_src_id         (i_src_id),
        .i_shared_in      (i_shared_in),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_bus_req        (o_bus_req),
        .o_proc_data      (o_proc_data),
        .o_bus_data       (o_bus_data),
        .o_bus_data_dest  (o_bus_data_dest),
        .o_assert_shared  (o_assert_shared),
        .o_addr_out       (o_addr_out),
        .o_miss_event     (o_miss_event),
        .o_upgrade_event  (o_upgrade_event),
        .o_status         (o_status),
        .o_line_state_out (o_line_state_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result with every flag clear, the given state and status
    function automatic t_result plain_result(t_line_state st, logic [1:0] stat);
        t_result r;
        r.bus_req        = BUS_NONE;
        r.proc_data      = 1'b0;
        r.bus_data       = 1'b0;
        r.bus_data_dest  = 4'd0;
        r.assert_shared  = 1'b0;
        r.addr_out       = 32'd0;
        r.miss_event     = 1'b0;
        r.upgrade_event  = 1'b0;
        r.status         = stat;
        r.line_state_out = st;
        return r;
    endfunction

    // Advance the line by one request and return what the block should report
    function automatic t_result coherence_step(t_item req);
        t_result     r;
        t_line_state st;
        logic        other;
        logic        is_store;
        r        = plain_result(ST_I, STAT_OK);
        st       = line_model;
        other    = (req.src_id != own_id_model);
        is_store = (req.op == OP_STORE);
        if (req.op > OP_DATA) begin
            r.status = STAT_ILLEGAL;
        end else if (req.op == OP_LOAD || is_store) begin
            case (st)
                ST_I: begin
                    r.miss_event = 1'b1;
                    if (is_store) begin
                        r.bus_req = BUS_GETM;
                        st = ST_IM;
                    end else begin
                        r.bus_req = BUS_GETS;
                        st = ST_IS;
                    end
                end
                ST_S, ST_O, ST_F: begin
                    if (is_store) begin
                        r.bus_req    = BUS_GETM;
                        r.miss_event = 1'b1;
                        if (st == ST_S) st = ST_IM;
                        else if (st == ST_O) st = ST_OM;
                        else st = ST_FM;
                    end else begin
                        r.proc_data = 1'b1;
                    end
                end
                ST_E: begin
                    r.proc_data = 1'b1;
                    if (is_store) begin
                        st = ST_M;
                        r.upgrade_event = 1'b1;
                    end
                end
                ST_M: begin
                    r.proc_data = 1'b1;
                end
                default: begin
                    r.status = STAT_IGNORED;
                end
            endcase
        end else begin
            case (st)
                ST_S: begin
                    if (req.op == OP_GETS) r.assert_shared = 1'b1;
                    else if (req.op == OP_GETM) st = ST_I;
                end
                ST_E, ST_M: begin
                    if (req.op == OP_GETS) begin
                        r.assert_shared = 1'b1;
                        r.bus_data = 1'b1;
                        if (st == ST_E) st = ST_F;
                        else st = ST_O;
                    end else if (req.op == OP_GETM) begin
                        r.assert_shared = 1'b1;
                        r.bus_data = 1'b1;
                        st = ST_I;
                    end
                end
                ST_O, ST_F: begin
                    if (req.op == OP_GETS) begin
                        r.assert_shared = 1'b1;
                        r.bus_data = 1'b1;
                    end else if (req.op == OP_GETM) begin
                        r.assert_shared = 1'b1;
                        r.bus_data = 1'b1;
                        st = ST_I;
                    end else if (st == ST_F) begin
                        r.status = STAT_ILLEGAL;
                    end
                end
                ST_IS: begin
                    if (req.op == OP_DATA) begin
                        r.proc_data = 1'b1;
                        if (req.shared_in) st = ST_S;
                        else st = ST_E;
                    end
                end
                ST_IM: begin
                    if (req.op == OP_DATA) begin
                        r.proc_data = 1'b1;
                        st = ST_M;
                    end
                end
                ST_SM: begin
                    if (req.op == OP_DATA) begin
                        r.proc_data = 1'b1;
                        st = ST_M;
                    end else begin
                        if (req.op == OP_GETS) r.assert_shared = 1'b1;
                        if (other) st = ST_IM;
                    end
                end
                ST_OM, ST_FM: begin
                    if (req.op == OP_GETS) begin
                        r.assert_shared = 1'b1;
                        r.bus_data = 1'b1;
                    end else if (req.op == OP_GETM) begin
                        // owner keeps the line in FM only against its own request
                        r.bus_data = 1'b1;
                        if (st == ST_OM || other) st = ST_IM;
                    end else begin
                        r.proc_data = 1'b1;
                        st = ST_M;
                    end
                end
                default: begin
                end
            endcase
        end
        if (r.bus_data) r.bus_data_dest = req.src_id;
        if (r.bus_req != BUS_NONE || r.proc_data || r.bus_data) r.addr_out = req.addr;
        r.line_state_out = st;
        line_model = st;
        return r;
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one
    function automatic int pause_len();
        int p;
        int len;
        p = $urandom_range(0, 99);
        if (p < 55) len = 0;
        else if (p < 90) len = $urandom_range(1, 3);
        else len = $urandom_range(8, 30);
        return len;
    endfunction

    // Weighted op mix; at least a third of requests carry this cache's own id
    function automatic t_item random_request();
        t_item req;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) req.op = OP_LOAD;
        else if (pick < 40) req.op = OP_STORE;
        else if (pick < 55) req.op = OP_GETS;
        else if (pick < 70) req.op = OP_GETM;
        else if (pick < 95) req.op = OP_DATA;
        else req.op = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
        req.addr = $urandom;
        if ($urandom_range(0, 2) == 0) req.src_id = own_id_model;
        else req.src_id = 4'($urandom_range(0, 15));
        req.shared_in = 1'($urandom_range(0, 1));
        return req;
    endfunction

    task automatic add_row(input logic [2:0] op, input logic [31:0] addr,
                           input logic [3:0] src, input logic shin);
        t_stim_row row;
        row.req.op        = op;
        row.req.addr      = addr;
        row.req.src_id    = src;
        row.req.shared_in = shin;
        row.pinned        = 1'b0;
        row.want          = plain_result(ST_I, STAT_OK);
        stim_rows.push_back(row);
    endtask

    task automatic pin_last(input t_result want);
        stim_rows[stim_rows.size() - 1].pinned = 1'b1;
        stim_rows[stim_rows.size() - 1].want   = want;
    endtask

    // Offer one request after an optional gap; return at the falling edge after transfer
    task automatic send_request(input t_item req, input bit pinned, input t_result want,
                                input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        drv_pinned   = pinned;
        drv_expect   = want;
        i_in_valid  <= 1'b1;
        i_op        <= req.op;
        i_addr      <= req.addr;
        i_src_id    <= req.src_id;
        i_shared_in <= req.shared_in;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every outstanding result has been taken
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_own_id(input logic [3:0] id);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= id;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Predict on each input transfer, compare on each output transfer
    always @(posedge i_clk) begin : scoreboard
        t_item   acc;
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) own_id_model = i_cfg_data;
            if (i_in_valid && !o_in_stall) begin
                acc.op        = i_op;
                acc.addr      = i_addr;
                acc.src_id    = i_src_id;
                acc.shared_in = i_shared_in;
                want = coherence_step(acc);
                if (drv_pinned) want = drv_expect;
                pending_results.push_back(want);
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with no outstanding expectation");
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("bus_req", 32'(want.bus_req), 32'(o_bus_req));
                    check_field("proc_data", 32'(want.proc_data), 32'(o_proc_data));
                    check_field("bus_data", 32'(want.bus_data), 32'(o_bus_data));
                    check_field("bus_data_dest", 32'(want.bus_data_dest),
                                32'(o_bus_data_dest));
                    check_field("assert_shared", 32'(want.assert_shared),
                                32'(o_assert_shared));
                    check_field("addr_out", want.addr_out, o_addr_out);
                    check_field("miss_event", 32'(want.miss_event), 32'(o_miss_event));
                    check_field("upgrade_event", 32'(want.upgrade_event),
                                32'(o_upgrade_event));
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("line_state_out", 32'(want.line_state_out),
                                32'(o_line_state_out));
                end
            end
        end
    end

    // Result side: random stalls, quiet stretches, one long hold on request
    initial begin : result_sink
        int run;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 7) == 0) run = $urandom_range(30, 60);
            else run = $urandom_range(1, 6);
            repeat (run) @(negedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                run = pause_len();
                if (run > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (run) @(negedge i_clk);
                end
            end
        end
    end

    // Abort when no transfer of any kind happens for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        wait (i_rst_n);
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("moesif_snoop_line_controller_unit regression: fail");
        $finish;
    end

    initial begin : stimulus
        t_result     want;
        logic [3:0]  id_plan[PHASE_COUNT];
        int          gap;

        // Directed walk through every stable state and the transient states IS, IM, OM and FM with own id 0
        add_row(OP_GETS, 32'h0000_0000, 4'h0, 1'b0);
        pin_last(plain_result(ST_I, STAT_OK));
        add_row(OP_BAD_HI, 32'hFFFF_FFFF, 4'hF, 1'b1);
        pin_last(plain_result(ST_I, STAT_ILLEGAL));
        add_row(OP_LOAD, 32'hFFFF_FFFF, 4'h0, 1'b0);
        want = plain_result(ST_IS, STAT_OK);
        want.bus_req    = BUS_GETS;
        want.miss_event = 1'b1;
        want.addr_out   = 32'hFFFF_FFFF;
        pin_last(want);
        // processor request while waiting for data is ignored
        add_row(OP_STORE, $urandom, 4'h7, 1'b0);
        pin_last(plain_result(ST_IS, STAT_IGNORED));
        add_row(OP_DATA, $urandom, 4'h2, 1'b1);
        add_row(OP_GETS, $urandom, 4'h4, 1'b0);
        // store in S goes straight to IM as a miss
        add_row(OP_STORE, $urandom, 4'h0, 1'b0);
        add_row(OP_DATA, $urandom, 4'h0, 1'b1);
        add_row(OP_GETS, $urandom, 4'h5, 1'b0);
        add_row(OP_STORE, $urandom, 4'h0, 1'b1);
        add_row(OP_GETS, $urandom, 4'hA, 1'b0);
        // data in OM also reaches the processor
        add_row(OP_DATA, $urandom, 4'h1, 1'b0);
        add_row(OP_GETS, $urandom, 4'h1, 1'b1);
        add_row(OP_STORE, $urandom, 4'h0, 1'b0);
        // GETM in OM drops to IM even for its own id
        add_row(OP_GETM, $urandom, 4'h0, 1'b0);
        add_row(OP_DATA, $urandom, 4'h6, 1'b1);
        add_row(OP_GETM, $urandom, 4'hF, 1'b0);
        add_row(OP_LOAD, $urandom, 4'h0, 1'b1);
        add_row(OP_DATA, $urandom, 4'h3, 1'b0);
        add_row(OP_GETS, $urandom, 4'h3, 1'b1);
        // data while in F is illegal
        add_row(OP_DATA, $urandom, 4'h8, 1'b1);
        pin_last(plain_result(ST_F, STAT_ILLEGAL));
        add_row(OP_STORE, $urandom, 4'h0, 1'b0);
        // GETM in FM: stay for own id, drop to IM otherwise
        add_row(OP_GETM, $urandom, 4'h0, 1'b0);
        add_row(OP_GETM, $urandom, 4'h9, 1'b1);
        add_row(OP_DATA, $urandom, 4'hC, 1'b0);
        add_row(OP_BAD_LO, 32'h0000_0000, 4'h0, 1'b0);
        pin_last(plain_result(ST_M, STAT_ILLEGAL));

        id_plan[0] = 4'hF;
        id_plan[1] = 4'h0;
        id_plan[2] = 4'($urandom_range(1, 14));
        id_plan[3] = 4'hF;
        id_plan[4] = 4'($urandom_range(0, 15));
        id_plan[5] = 4'($urandom_range(0, 15));

        // Hold reset, then release it on a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k])
            send_request(stim_rows[k].req, stim_rows[k].pinned, stim_rows[k].want,
                         pause_len());

        // Random phases, each under its own id and started from an empty pipe
        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_all_results();
            write_own_id(id_plan[p]);
            if (p == 1) hold_pending = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k < 20) gap = 0;
                else gap = pause_len();
                send_request(random_request(), 1'b0, plain_result(ST_I, STAT_OK), gap);
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("moesif_snoop_line_controller_unit regression: pass");
        else
            $display("moesif_snoop_line_controller_unit regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/msl_pkg.sv
hw/rtl/msl_transition.sv
hw/rtl/moesif_snoop_line_controller_unit.sv
tb/tb_top.sv
